@@ hw/rtl/oscp_pkg.sv @@
// Package for the OSC message parser: constants, result kinds, status codes.
// No dependencies.
`timescale 1ns / 1ps
package oscp_pkg;
  localparam int MAX_TAGS = 16;
  localparam int TAG_AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int CNT_W = 5;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_S = 8'h73;

  localparam logic [2:0] K_ADDR = 3'd0;
  localparam logic [2:0] K_INT = 3'd1;
  localparam logic [2:0] K_FLOAT = 3'd2;
  localparam logic [2:0] K_SBYTE = 3'd3;
  localparam logic [2:0] K_SEND = 3'd4;
  localparam logic [2:0] K_UNSUP = 3'd5;
  localparam logic [2:0] K_TRUNC = 3'd6;
  localparam logic [2:0] K_STATUS = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_OSC = 2'd1;
  localparam logic [1:0] ST_NO_TAGS = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;
endpackage

@@ hw/rtl/osc_message_parser.sv @@
// OSC 1.0 message parser: one packet byte a beat in, typed records out.
// Output: a record is registered at the edge that takes its byte; a record that closes an
// argument is held in hd_r and goes out from S_FLUSH once the next tag has been read and checked.
// Throughput: 1 byte per cycle while the output is free; a byte that closes an argument, the tag
// string or the packet holds in_tready low for a tag walk, one tag memory read for each further record.
// Reset: synchronous active-low; parser returns to address start, output empty.
// Depends on oscp_pkg.
`timescale 1ns / 1ps
module osc_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // packet_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] value,[36:32] arg_index,[37] truncated,[39:38] status
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // run_last
);
  import oscp_pkg::*;

  typedef enum logic [2:0] {
    PH_ADDR_FIRST, PH_ADDR_BODY, PH_ADDR_PAD, PH_TAG_FIRST,
    PH_TAG_BODY, PH_TAG_PAD, PH_ARGS
  } phase_t;

  // FSM: S_IDLE takes bytes; S_FLUSH walks unsupported tags and releases the
  // held record; S_END walks tags at packet end and emits the status record.
  typedef enum logic [1:0] {S_IDLE, S_FLUSH, S_END} ctl_t;

  logic [7:0] tag_mem [MAX_TAGS];
  logic [7:0] rd_data_r;

  phase_t phase_r;
  ctl_t   ctl_r;
  logic [1:0] align_r;
  logic [CNT_W-1:0] total_r, cursor_r;
  logic [1:0] wbytes_r;
  logic [31:0] accum_r;
  logic [1:0] perr_r;
  logic stopped_r;
  logic pend_r;          // tag at cursor already read into rd_data_r
  logic last_r;
  logic busy_r;          // a taken byte still has follow-up work
  logic hv_r;            // record held until it is known whether more follow
  logic [42:0] hd_r;

  logic        ov_r;
  logic [42:0] od_r;
  logic        ol_r;
  logic        ofree;
  assign ofree = !ov_r || out_tready;
  assign out_tvalid = ov_r;
  assign out_tuser = od_r[2:0];
  assign out_tdata = od_r[42:3];
  assign out_tlast = ol_r;

  logic tag_rdy;
  assign tag_rdy = (cursor_r < total_r);

  // Tag memory read address: always the cursor.
  logic [CNT_W-1:0] rd_addr;
  logic wr_en;
  logic [7:0] wr_data;

  logic pend_r_ok;
  assign pend_r_ok = !(phase_r == PH_ARGS && tag_rdy && !pend_r);
  assign in_tready = rst_n && ctl_r == S_IDLE && !busy_r && ofree && pend_r_ok;

  function automatic logic [42:0] pack(logic [2:0] k, logic [31:0] v,
                                       logic [CNT_W-1:0] ix, logic tr, logic [1:0] st);
    pack = {st, tr, ix, v, k};
  endfunction

  logic is_num, is_str;
  assign is_num = (rd_data_r == CH_I) || (rd_data_r == CH_F);
  assign is_str = (rd_data_r == CH_S);

  always_ff @(posedge clk) begin
    if (wr_en) tag_mem[total_r[TAG_AW-1:0]] <= wr_data;
    rd_data_r <= tag_mem[rd_addr[TAG_AW-1:0]];
  end

  logic take;
  assign take = in_tvalid && in_tready;

  logic [1:0] na;
  assign na = align_r + 2'd1;

  always_comb begin
    wr_en = 1'b0;
    wr_data = in_tdata;
    rd_addr = cursor_r;
    if (take && !stopped_r && phase_r == PH_TAG_BODY && in_tdata != 8'd0 &&
        total_r < CNT_W'(MAX_TAGS))
      wr_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR_FIRST; ctl_r <= S_IDLE; align_r <= '0;
      total_r <= '0; cursor_r <= '0; wbytes_r <= '0; accum_r <= '0;
      perr_r <= '0; stopped_r <= 1'b0; pend_r <= 1'b0; ov_r <= 1'b0;
      last_r <= 1'b0; busy_r <= 1'b0; hv_r <= 1'b0; hd_r <= '0;
      od_r <= '0; ol_r <= 1'b0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      // read data becomes valid in the cycle after the cursor settles
      if (!pend_r && tag_rdy && phase_r == PH_ARGS) pend_r <= 1'b1;
      if (take) begin
        align_r <= na;
        last_r <= in_tlast;
        if (!stopped_r) begin
          case (phase_r)
            PH_ADDR_FIRST:
              if (in_tdata == CH_SLASH) begin
                phase_r <= PH_ADDR_BODY;
                ov_r <= 1'b1; ol_r <= !in_tlast;
                od_r <= pack(K_ADDR, {24'd0, in_tdata}, '0, 1'b0, ST_OK);
              end else begin
                perr_r <= ST_NOT_OSC; stopped_r <= 1'b1;
              end
            PH_ADDR_BODY:
              if (in_tdata != 8'd0) begin
                ov_r <= 1'b1; ol_r <= !in_tlast;
                od_r <= pack(K_ADDR, {24'd0, in_tdata}, '0, 1'b0, ST_OK);
              end else phase_r <= (na == 2'd0) ? PH_TAG_FIRST : PH_ADDR_PAD;
            PH_ADDR_PAD: if (na == 2'd0) phase_r <= PH_TAG_FIRST;
            PH_TAG_FIRST:
              if (in_tdata == CH_COMMA) phase_r <= PH_TAG_BODY;
              else begin perr_r <= ST_NO_TAGS; stopped_r <= 1'b1; end
            PH_TAG_BODY:
              if (in_tdata == 8'd0) begin
                if (na == 2'd0) begin
                  phase_r <= PH_ARGS; cursor_r <= '0; pend_r <= 1'b0;
                  wbytes_r <= '0; accum_r <= '0;
                  if (total_r != '0) busy_r <= 1'b1; // flush check at cursor 0
                  else busy_r <= 1'b0;
                end else phase_r <= PH_TAG_PAD;
              end else if (total_r < CNT_W'(MAX_TAGS)) total_r <= total_r + CNT_W'(1);
              else perr_r <= ST_DROPPED;
            PH_TAG_PAD:
              if (na == 2'd0) begin
                phase_r <= PH_ARGS; cursor_r <= '0; pend_r <= 1'b0;
                wbytes_r <= '0; accum_r <= '0;
                busy_r <= (total_r != '0);
              end
            PH_ARGS:
              if (tag_rdy) begin
                if (is_num) begin
                  accum_r <= {accum_r[23:0], in_tdata};
                  if (wbytes_r == 2'd3) begin
                    hv_r <= 1'b1;
                    hd_r <= pack((rd_data_r == CH_I) ? K_INT : K_FLOAT,
                                 {accum_r[23:0], in_tdata}, cursor_r, 1'b0, ST_OK);
                    cursor_r <= cursor_r + CNT_W'(1); pend_r <= 1'b0;
                    wbytes_r <= '0; accum_r <= '0; busy_r <= 1'b1;
                  end else wbytes_r <= wbytes_r + 2'd1;
                end else if (is_str) begin
                  if (wbytes_r == 2'd0 && in_tdata != 8'd0) begin
                    ov_r <= 1'b1; ol_r <= !in_tlast;
                    od_r <= pack(K_SBYTE, {24'd0, in_tdata}, cursor_r, 1'b0, ST_OK);
                  end else begin
                    wbytes_r <= 2'd1;
                    if (na == 2'd0) begin
                      hv_r <= 1'b1;
                      hd_r <= pack(K_SEND, 32'd0, cursor_r, 1'b0, ST_OK);
                      cursor_r <= cursor_r + CNT_W'(1); pend_r <= 1'b0;
                      wbytes_r <= '0; accum_r <= '0; busy_r <= 1'b1;
                    end
                  end
                end
              end
            default: ;
          endcase
        end
        if (in_tlast) begin
          busy_r <= 1'b1;
        end
      end
      // follow-up work after a byte: flush then end-of-packet
      if (busy_r && ctl_r == S_IDLE && !take) begin
        if (phase_r == PH_ARGS && !stopped_r) ctl_r <= S_FLUSH;
        else ctl_r <= S_END;
        busy_r <= 1'b0;
      end
      // the held record goes out marked last only when no unsupported tag follows
      if (ctl_r == S_FLUSH && ofree) begin
        if (!tag_rdy || (pend_r && (is_num || is_str))) begin
          if (hv_r) begin
            ov_r <= 1'b1; od_r <= hd_r; ol_r <= !last_r; hv_r <= 1'b0;
          end
          ctl_r <= last_r ? S_END : S_IDLE;
        end else if (pend_r) begin
          if (hv_r) begin
            ov_r <= 1'b1; od_r <= hd_r; ol_r <= 1'b0;
          end
          hv_r <= 1'b1;
          hd_r <= pack(K_UNSUP, {24'd0, rd_data_r}, cursor_r, 1'b0, ST_OK);
          cursor_r <= cursor_r + CNT_W'(1); pend_r <= 1'b0;
        end
      end
      if (ctl_r == S_END && ofree) begin
        if (!last_r) ctl_r <= S_IDLE;
        else if (!stopped_r && phase_r == PH_ARGS && tag_rdy) begin
          if (pend_r) begin
            ov_r <= 1'b1; ol_r <= 1'b0;
            if (is_num) begin
              od_r <= pack(K_TRUNC, {24'd0, rd_data_r}, cursor_r, 1'b0, ST_OK);
              cursor_r <= total_r;
            end else begin
              od_r <= is_str ? pack(K_SEND, 32'd0, cursor_r, 1'b1, ST_OK)
                             : pack(K_UNSUP, {24'd0, rd_data_r}, cursor_r, 1'b0, ST_OK);
              cursor_r <= cursor_r + CNT_W'(1); pend_r <= 1'b0;
            end
          end
        end else begin
          ov_r <= 1'b1; ol_r <= 1'b1;
          od_r <= pack(K_STATUS, 32'd0, '0, 1'b0,
                       stopped_r ? perr_r :
                       (phase_r <= PH_ADDR_PAD) ? ST_NOT_OSC :
                       (phase_r <= PH_TAG_PAD) ? ST_NO_TAGS : perr_r);
          phase_r <= PH_ADDR_FIRST; align_r <= '0; total_r <= '0; cursor_r <= '0;
          wbytes_r <= '0; accum_r <= '0; perr_r <= '0; stopped_r <= 1'b0;
          pend_r <= 1'b0; last_r <= 1'b0; ctl_r <= S_IDLE;
        end
      end
    end
  end

`ifndef SYNTH
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r != S_IDLE |-> !in_tready) else $error("byte taken during walk");
  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= total_r) else $error("cursor past tag count");
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(MAX_TAGS)) else $error("tag count overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r |-> (busy_r || ctl_r == S_FLUSH)) else $error("held record outside walk");
`endif
endmodule

@@ verif/osc_message_parser_tb.sv @@
// Testbench for osc_message_parser: byte stream of OSC packets in, typed records out.
// A built-in model predicts every record, which is compared field by field. Uses oscp_pkg.
`timescale 1ns / 1ps
module osc_message_parser_tb;
  import oscp_pkg::*;

  typedef struct packed {
    logic       run_last;
    logic [1:0] status;
    logic       truncated;
    logic [4:0] arg_index;
    logic [31:0] value;
    logic [2:0] kind;
  } rec_t;

  typedef enum logic [2:0] {
    P_ADDR_FIRST, P_ADDR_BODY, P_ADDR_PAD, P_TAG_FIRST, P_TAG_BODY, P_TAG_PAD, P_ARGS
  } phase_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;

  osc_message_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // parser model state
  phase_t     ph;
  int         align_q;
  logic [7:0] tags [MAX_TAGS];
  int         tag_cnt, cur;
  int         wbytes;
  logic [31:0] accum;
  logic [1:0] perr;
  bit         halted;

  rec_t expected_recs [$];
  rec_t step_recs [$];
  int   mismatches = 0;
  int   send_idle = 0, recv_idle = 0;
  bit   timed_out = 0;

  function automatic bit is_known(logic [7:0] t);
    return t == CH_I || t == CH_F || t == CH_S;
  endfunction

  function automatic void push_rec(logic [2:0] k, logic [31:0] v, int idx, bit tr,
                                   logic [1:0] st);
    rec_t r;
    r = '{run_last: 1'b0, status: st, truncated: tr, arg_index: idx[4:0], value: v, kind: k};
    step_recs.push_back(r);
  endfunction

  function automatic void clear_parser();
    ph = P_ADDR_FIRST; align_q = 0; tag_cnt = 0; cur = 0; wbytes = 0; accum = 0;
    perr = ST_OK; halted = 0;
  endfunction

  function automatic void skip_unknown();
    while (cur < tag_cnt && !is_known(tags[cur])) begin
      push_rec(K_UNSUP, {24'd0, tags[cur]}, cur, 0, ST_OK);
      cur++;
    end
  endfunction

  function automatic void advance_tag();
    cur++; wbytes = 0; accum = 0;
    skip_unknown();
  endfunction

  function automatic void enter_args();
    ph = P_ARGS; cur = 0; wbytes = 0; accum = 0;
    skip_unknown();
  endfunction

  function automatic void predict_byte(logic [7:0] b, bit last);
    int na;
    logic [1:0] st;
    step_recs.delete();
    na = (align_q + 1) & 3;
    align_q = na;
    if (!halted) begin
      case (ph)
        P_ADDR_FIRST: begin
          if (b == CH_SLASH) begin
            push_rec(K_ADDR, {24'd0, b}, 0, 0, ST_OK); ph = P_ADDR_BODY;
          end else begin
            perr = ST_NOT_OSC; halted = 1;
          end
        end
        P_ADDR_BODY: begin
          if (b != 0) push_rec(K_ADDR, {24'd0, b}, 0, 0, ST_OK);
          else ph = (na == 0) ? P_TAG_FIRST : P_ADDR_PAD;
        end
        P_ADDR_PAD: if (na == 0) ph = P_TAG_FIRST;
        P_TAG_FIRST: begin
          if (b == CH_COMMA) ph = P_TAG_BODY;
          else begin
            perr = ST_NO_TAGS; halted = 1;
          end
        end
        P_TAG_BODY: begin
          if (b == 0) begin
            if (na == 0) enter_args();
            else ph = P_TAG_PAD;
          end else if (tag_cnt < MAX_TAGS) begin
            tags[tag_cnt] = b; tag_cnt++;
          end else perr = ST_DROPPED;
        end
        P_TAG_PAD: if (na == 0) enter_args();
        P_ARGS: begin
          if (cur < tag_cnt) begin
            if (tags[cur] == CH_I || tags[cur] == CH_F) begin
              accum = {accum[23:0], b};
              if (wbytes == 3) begin
                push_rec(tags[cur] == CH_I ? K_INT : K_FLOAT, accum, cur, 0, ST_OK);
                advance_tag();
              end else wbytes++;
            end else if (tags[cur] == CH_S) begin
              if (wbytes == 0 && b != 0) push_rec(K_SBYTE, {24'd0, b}, cur, 0, ST_OK);
              else begin
                wbytes = 1;
                if (na == 0) begin
                  push_rec(K_SEND, 0, cur, 0, ST_OK); advance_tag();
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (last) begin
      if (halted) st = perr;
      else if (ph <= P_ADDR_PAD) st = ST_NOT_OSC;
      else if (ph <= P_TAG_PAD) st = ST_NO_TAGS;
      else st = perr;
      if (!halted && ph == P_ARGS) begin
        while (cur < tag_cnt) begin
          if (tags[cur] == CH_I || tags[cur] == CH_F) begin
            push_rec(K_TRUNC, {24'd0, tags[cur]}, cur, 0, ST_OK);
            break;
          end
          if (tags[cur] == CH_S) push_rec(K_SEND, 0, cur, 1, ST_OK);
          else push_rec(K_UNSUP, {24'd0, tags[cur]}, cur, 0, ST_OK);
          cur++;
        end
      end
      push_rec(K_STATUS, 0, 0, 0, st);
      clear_parser();
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].run_last = 1'b1;
    foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
  endfunction

  // send one byte; model is updated when the beat is taken
  task automatic send_byte(logic [7:0] b, bit last);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1; in_tdata <= b; in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b, last);
    @(negedge clk);
  endtask

  always @(negedge clk)
    out_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    rec_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata, out_tuser};
      if (expected_recs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %h", got);
      end else begin
        want = expected_recs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: kind %0d/%0d value %h/%h idx %0d/%0d trunc %0d/%0d st %0d/%0d last %0d/%0d",
                     want.kind, got.kind, want.value, got.value, want.arg_index, got.arg_index,
                     want.truncated, got.truncated, want.status, got.status,
                     want.run_last, got.run_last);
        end
      end
    end
  end

  task automatic send_packet(logic [7:0] bytes [$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  function automatic void add_padded(ref logic [7:0] q [$], input logic [7:0] s [$]);
    foreach (s[i]) q.push_back(s[i]);
    q.push_back(8'd0);
    while (q.size() % 4 != 0) q.push_back(8'($urandom_range(255)));
  endfunction

  // builds a well-formed message with random content; sometimes given trailing bytes or cut short
  function automatic void build_message(ref logic [7:0] q [$], input int ntags);
    logic [7:0] s [$];
    logic [7:0] tl [$];
    int n;
    q.delete();
    s.push_back(CH_SLASH);
    n = $urandom_range(5);
    repeat (n) s.push_back(8'($urandom_range(1, 255)));
    add_padded(q, s);
    tl.push_back(CH_COMMA);
    for (int i = 0; i < ntags; i++) begin
      case ($urandom_range(9))
        0, 1, 2: tl.push_back(CH_I);
        3, 4: tl.push_back(CH_F);
        5, 6, 7: tl.push_back(CH_S);
        default: tl.push_back(8'($urandom_range(1, 255)));
      endcase
    end
    add_padded(q, tl);
    for (int i = 1; i < tl.size() && i <= MAX_TAGS; i++) begin
      if (tl[i] == CH_I || tl[i] == CH_F) repeat (4) q.push_back(8'($urandom_range(255)));
      else if (tl[i] == CH_S) begin
        s.delete();
        n = $urandom_range(6);
        repeat (n) s.push_back(8'($urandom_range(1, 255)));
        add_padded(q, s);
      end
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(255)));
    if ($urandom_range(3) == 0 && q.size() > 1) begin
      n = $urandom_range(1, q.size() - 1);
      while (q.size() > n) void'(q.pop_back());
    end
  endfunction

  task automatic wait_drained();
    in_tvalid <= 0;
    while (expected_recs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [7:0] p [$];
    p = '{CH_SLASH, 8'h61, 0, 0, CH_COMMA, CH_I, CH_F, CH_S,
          8'h78, 0, 0, 0, 8'h80, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'h68, 8'h69, 0, 0};
    send_packet(p);                                         // ok + unsupported run
    send_packet('{8'h00});                                  // empty address
    send_packet('{8'h41, 8'h2F, 8'h00});                    // bad first byte
    send_packet('{CH_SLASH, 8'h7F});                        // address unterminated
    send_packet('{CH_SLASH, 0, 0, 0, 8'h2D, 0, 0, 0});      // tag string without comma
    send_packet('{CH_SLASH, 0, 0, 0, CH_COMMA, CH_S});      // tags unterminated
    send_packet('{CH_SLASH, 0, 0, 0, CH_COMMA, CH_S, CH_S, CH_I, 0, 0, 0, 0, 8'h41});
    send_packet('{CH_SLASH, 0, 0, 0, CH_COMMA, CH_F, 0, 0, 8'h01});
  endtask

  task automatic test_excess_tags();
    logic [7:0] p [$];
    p = '{CH_SLASH, 0, 0, 0, CH_COMMA};
    repeat (MAX_TAGS + 2) p.push_back(8'h7A);
    p.push_back(8'd0);
    while (p.size() % 4 != 0) p.push_back(8'd0);
    p.push_back(8'hAA);
    send_packet(p);
  endtask

  task automatic test_random(int budget);
    logic [7:0] p [$];
    int sent;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) == 0) begin
        p.delete();
        repeat ($urandom_range(1, 8)) p.push_back(8'($urandom_range(255)));
        if ($urandom_range(1)) p[0] = CH_SLASH;
      end else
        build_message(p, $urandom_range(9) == 0 ? $urandom_range(MAX_TAGS, MAX_TAGS + 3)
                                                : $urandom_range(0, 4));
      send_packet(p);
      sent += p.size();
    end
  endtask

  initial begin
    clear_parser();
    repeat (6) @(negedge clk);
    rst_n = 1;
    test_directed();
    test_excess_tags();
    wait_drained();
    test_random(50);
    send_idle = 63;
    test_random(50);
    wait_drained();                                         // sender holds off until drained
    send_idle = 0; recv_idle = 63;
    test_random(50);
    send_idle = 25; recv_idle = 25;
    test_random(50);
    wait_drained();
    if (mismatches == 0 && !timed_out) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    timed_out = 1;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
